FILE: src/text_console_writer_macros.svh
// Assertion macros for the text console writer RTL.
// Depends on nothing; the including module provides clk and rst.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Depends on nothing; used by the front, queue, back and top level.
package tcw_pkg;

  localparam int KIND_W       = 2;
  localparam int CHAR_W       = 8;
  localparam int ATTR_W       = 8;
  localparam int READ_ROW_W   = 5;
  localparam int READ_COL_W   = 7;
  localparam int CURSOR_ROW_W = 5;
  localparam int CURSOR_COL_W = 7;
  localparam int CELL_W       = 16;
  // Widest row and column over the supported screen sizes.
  localparam int ROW_MAX_W    = 7;
  localparam int COL_MAX_W    = 8;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;
  localparam logic [ATTR_W-1:0] BLANK_ATTR     = 8'h0F;
  localparam logic [CELL_W-1:0] BLANK_CELL     = {BLANK_ATTR, CHAR_SPACE};

  typedef enum logic [2:0] {
    CMD_REPORT,
    CMD_WRITE,
    CMD_SCROLL,
    CMD_WRITE_SCROLL,
    CMD_READ,
    CMD_CLEAR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t                 op;
    logic [ROW_MAX_W-1:0]    row;
    logic [COL_MAX_W-1:0]    col;
    logic [CELL_W-1:0]       data;
    logic [CURSOR_ROW_W-1:0] res_row;
    logic [CURSOR_COL_W-1:0] res_col;
  } cmd_t;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_SWEEP,
    S_DONE
  } back_state_t;

endpackage

FILE: src/tcw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/tcw_front.sv
// Front end: accepts items, tracks the cursor and classifies each item into a command.
// Depends on tcw_pkg.
module tcw_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [tcw_pkg::KIND_W-1:0]     kind,
  input  logic [tcw_pkg::CHAR_W-1:0]     char_code,
  input  logic [tcw_pkg::ATTR_W-1:0]     attribute,
  input  logic [tcw_pkg::READ_ROW_W-1:0] read_row,
  input  logic [tcw_pkg::READ_COL_W-1:0] read_col,
  input  logic                          q_full,
  input  logic                          init_busy,
  output logic                          push,
  output tcw_pkg::cmd_t                  push_cmd
);
  import tcw_pkg::*;

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLUMNS);

  logic [RW-1:0] row;
  logic [RW-1:0] row_next;
  logic [CW-1:0] col;
  logic [CW-1:0] col_next;
  logic          row_adv;
  logic          write;
  logic          scroll;

  assign item_stall = q_full | init_busy;
  assign push       = item_valid & ~item_stall;

  always_comb begin
    push_cmd      = '0;
    push_cmd.op   = CMD_REPORT;
    push_cmd.row  = ROW_MAX_W'(row);
    push_cmd.col  = COL_MAX_W'(col);
    push_cmd.data = {attribute, char_code};
    row_next      = row;
    col_next      = col;
    row_adv       = 1'b0;
    write         = 1'b0;
    scroll        = 1'b0;
    case (kind)
      KIND_PUT: begin
        if (char_code == CHAR_NEWLINE) begin
          col_next = '0;
          row_adv  = 1'b1;
        end else if (char_code == CHAR_BACKSPACE) begin
          if (col != '0) begin
            col_next      = col - 1'b1;
            write         = 1'b1;
            push_cmd.col  = COL_MAX_W'(col - 1'b1);
            push_cmd.data = {attribute, CHAR_SPACE};
          end
        end else begin
          write = 1'b1;
          if (col == CW'(COLUMNS - 1)) begin
            col_next = '0;
            row_adv  = 1'b1;
          end else begin
            col_next = col + 1'b1;
          end
        end
        // Past the last row: scroll and hold the cursor on the bottom row
        if (row_adv) begin
          if (row == RW'(ROWS - 1)) begin
            scroll = 1'b1;
          end else begin
            row_next = row + 1'b1;
          end
        end
        if (write && scroll) begin
          push_cmd.op = CMD_WRITE_SCROLL;
        end else if (write) begin
          push_cmd.op = CMD_WRITE;
        end else if (scroll) begin
          push_cmd.op = CMD_SCROLL;
        end
      end
      KIND_READ: begin
        push_cmd.row = ROW_MAX_W'(read_row);
        push_cmd.col = COL_MAX_W'(read_col);
        if ((32'(read_row) < ROWS) && (32'(read_col) < COLUMNS)) begin
          push_cmd.op = CMD_READ;
        end
      end
      KIND_CLEAR: begin
        row_next    = '0;
        col_next    = '0;
        push_cmd.op = CMD_CLEAR;
      end
      default: begin
        push_cmd.op = CMD_REPORT;
      end
    endcase
    push_cmd.res_row = CURSOR_ROW_W'(row_next);
    push_cmd.res_col = CURSOR_COL_W'(col_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (push) begin
      row <= row_next;
      col <= col_next;
    end
  end

endmodule

FILE: src/tcw_queue.sv
// Short command queue between the front end and the back end.
// Depends on tcw_pkg.
module tcw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tcw_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output tcw_pkg::cmd_t head_cmd
);
  import tcw_pkg::*;

  localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  cmd_t           slots [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic [QCW-1:0] count;

  assign full       = (count == QCW'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: src/tcw_back.sv
// Back end: carries out commands on the screen store and registers each result.
// Depends on tcw_pkg, tcw_ram and text_console_writer_macros.svh.
`include "text_console_writer_macros.svh"

module tcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            head_valid,
  input  tcw_pkg::cmd_t                    head_cmd,
  output logic                            pop,
  output logic                            init_busy,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [tcw_pkg::CHAR_W-1:0]       cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]       cell_attr,
  output logic [tcw_pkg::CURSOR_ROW_W-1:0] cursor_row,
  output logic [tcw_pkg::CURSOR_COL_W-1:0] cursor_col,
  output logic                            scrolled
);
  import tcw_pkg::*;

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);

  back_state_t   state;
  back_state_t   state_next;
  cmd_t          cur;
  logic [RW-1:0] top;
  logic [AW-1:0] sweep_addr;
  logic [AW-1:0] sweep_last;

  logic [RW:0]     row_sum;
  logic [RW-1:0]   phys_row;
  logic [AW-1:0]   cell_addr;
  logic [AW-1:0]   top_base;
  logic            sweep_done;
  logic            slot_free;
  logic            load_result;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic            ram_re;
  logic [CELL_W-1:0] ram_rdata;

  // Map the logical row through the rotating top-row pointer
  always_comb begin
    row_sum = {1'b0, top} + (RW + 1)'(RW'(head_cmd.row));
    if (row_sum >= (RW + 1)'(ROWS)) begin
      phys_row = RW'(row_sum - (RW + 1)'(ROWS));
    end else begin
      phys_row = RW'(row_sum);
    end
    cell_addr = AW'(AW'(phys_row) * AW'(COLUMNS)) + AW'(CW'(head_cmd.col));
    top_base  = AW'(AW'(top) * AW'(COLUMNS));
  end

  assign sweep_done = (sweep_addr == sweep_last);
  assign slot_free  = ~result_valid | ~result_stall;
  assign init_busy  = (state == S_INIT);

  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (sweep_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (head_valid) begin
          case (head_cmd.op)
            CMD_SCROLL, CMD_WRITE_SCROLL, CMD_CLEAR: state_next = S_SWEEP;
            default:                                 state_next = S_DONE;
          endcase
        end
      end
      S_SWEEP: begin
        if (sweep_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  always_comb begin
    pop         = 1'b0;
    load_result = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = cell_addr;
    ram_wdata   = head_cmd.data;
    ram_re      = 1'b0;
    case (state)
      S_INIT, S_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_addr;
        ram_wdata = BLANK_CELL;
      end
      S_IDLE: begin
        pop = head_valid;
        if (head_valid) begin
          case (head_cmd.op)
            CMD_WRITE, CMD_WRITE_SCROLL: ram_we = 1'b1;
            CMD_READ:                    ram_re = 1'b1;
            default:                     ram_we = 1'b0;
          endcase
        end
      end
      S_DONE: begin
        load_result = slot_free;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cell_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      top          <= '0;
      sweep_addr   <= '0;
      sweep_last   <= AW'(CELLS - 1);
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && head_valid) begin
        case (head_cmd.op)
          CMD_SCROLL, CMD_WRITE_SCROLL: begin
            // Old top row becomes the new bottom row: blank it
            sweep_addr <= top_base;
            sweep_last <= top_base + AW'(COLUMNS - 1);
            top        <= (top == RW'(ROWS - 1)) ? '0 : top + 1'b1;
          end
          CMD_CLEAR: begin
            sweep_addr <= '0;
            sweep_last <= AW'(CELLS - 1);
            top        <= '0;
          end
          default: begin
            top <= top;
          end
        endcase
      end else if (state == S_SWEEP || state == S_INIT) begin
        sweep_addr <= sweep_addr + 1'b1;
      end
      if (load_result) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_cmd;
    end
    if (load_result) begin
      cell_char  <= (cur.op == CMD_READ) ? ram_rdata[CHAR_W-1:0] : '0;
      cell_attr  <= (cur.op == CMD_READ) ? ram_rdata[CELL_W-1:CHAR_W] : '0;
      cursor_row <= cur.res_row;
      cursor_col <= cur.res_col;
      scrolled   <= (cur.op == CMD_SCROLL) || (cur.op == CMD_WRITE_SCROLL);
    end
  end

  `TCW_ASSERT_NOW(a_init_quiet, state == S_INIT, !result_valid,
                  "result during clearing pass")
  `TCW_ASSERT_NOW(a_sweep_bound, (state == S_SWEEP) || (state == S_INIT),
                  sweep_addr <= sweep_last, "sweep ran past its last cell")
  `TCW_ASSERT_NEXT(a_done_loads, (state == S_DONE) && slot_free, result_valid,
                   "finished command produced no result")
  `TCW_ASSERT_NOW(a_scroll_bottom, result_valid && scrolled,
                  cursor_row == CURSOR_ROW_W'(ROWS - 1), "scroll left cursor off bottom row")

endmodule

FILE: src/text_console_writer.sv
// Text console writer: ROWS x COLUMNS character/attribute store with a cursor. A front end
// accepts one item per cycle while item_stall is low into a two-entry command queue and
// tracks the cursor; the back end owns the cell memory (one write and one read port) and a
// rotating top-row pointer. In the back end an ordinary put, backspace, newline or read goes
// from idle straight to done, a put that scrolls passes through a sweep state (one memory
// write per cell of the new bottom row), and a clear sweeps every cell. After reset a
// clearing pass writes every cell once, during which item_stall stays high.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic [tcw_pkg::KIND_W-1:0]       kind,
  input  logic [tcw_pkg::CHAR_W-1:0]       char_code,
  input  logic [tcw_pkg::ATTR_W-1:0]       attribute,
  input  logic [tcw_pkg::READ_ROW_W-1:0]   read_row,
  input  logic [tcw_pkg::READ_COL_W-1:0]   read_col,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [tcw_pkg::CHAR_W-1:0]       cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]       cell_attr,
  output logic [tcw_pkg::CURSOR_ROW_W-1:0] cursor_row,
  output logic [tcw_pkg::CURSOR_COL_W-1:0] cursor_col,
  output logic                            scrolled
);
  import tcw_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;
  logic init_busy;

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .kind       (kind),
    .char_code  (char_code),
    .attribute  (attribute),
    .read_row   (read_row),
    .read_col   (read_col),
    .q_full     (q_full),
    .init_busy  (init_busy),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  tcw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_cmd     (head_cmd),
    .pop          (pop),
    .init_busy    (init_busy),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cell_char    (cell_char),
    .cell_attr    (cell_attr),
    .cursor_row   (cursor_row),
    .cursor_col   (cursor_col),
    .scrolled     (scrolled)
  );

endmodule

FILE: test/text_console_writer_test.sv
// Self-checking testbench for text_console_writer: a directed table with typed reports,
// then random text, newline runs, reads and noise, checked against a cycle-free model.
// Depends on tcw_pkg and the text_console_writer RTL.
module text_console_writer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int COLS = 80;
  localparam int LINES = 25;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
  localparam int RANDOM_ITEMS = 500;
  localparam int STEP_COUNT = 22;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [CHAR_W-1:0]     char_code;
    logic [ATTR_W-1:0]     attr;
    logic [READ_ROW_W-1:0] row;
    logic [READ_COL_W-1:0] col;
  } console_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0]       ch;
    logic [ATTR_W-1:0]       attr;
    logic [CURSOR_ROW_W-1:0] row;
    logic [CURSOR_COL_W-1:0] col;
    logic                    scrolled;
  } console_report_t;

  typedef struct packed {
    console_item_t   item;
    logic            typed;
    console_report_t want;
  } console_step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [KIND_W-1:0] kind = '0;
  logic [CHAR_W-1:0] char_code = '0;
  logic [ATTR_W-1:0] attribute = '0;
  logic [READ_ROW_W-1:0] read_row = '0;
  logic [READ_COL_W-1:0] read_col = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [CHAR_W-1:0] cell_char;
  logic [ATTR_W-1:0] cell_attr;
  logic [CURSOR_ROW_W-1:0] cursor_row;
  logic [CURSOR_COL_W-1:0] cursor_col;
  logic scrolled;

  // Model of the screen and cursor.
  logic [CELL_W-1:0] screen [LINES][COLS];
  int cur_line;
  int cur_column;

  console_report_t awaited_reports[$];
  console_report_t got_report;
  console_report_t want_report;
  int mismatch_count = 0;
  int counted_items = 0;
  bit quiet = 1'b0;

  text_console_writer uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .kind(kind), .char_code(char_code), .attribute(attribute),
    .read_row(read_row), .read_col(read_col),
    .result_valid(result_valid), .result_stall(result_stall),
    .cell_char(cell_char), .cell_attr(cell_attr),
    .cursor_row(cursor_row), .cursor_col(cursor_col), .scrolled(scrolled)
  );

  always #5 clk = ~clk;

  function automatic void blank_screen();
    for (int r = 0; r < LINES; r++)
      for (int c = 0; c < COLS; c++)
        screen[r][c] = BLANK_CELL;
    cur_line = 0;
    cur_column = 0;
  endfunction

  function automatic console_report_t console_apply(console_item_t it);
    console_report_t rep;
    rep = '0;
    case (it.kind)
      KIND_PUT: begin
        if (it.char_code == CHAR_NEWLINE) begin
          cur_column = 0;
          cur_line++;
        end else if (it.char_code == CHAR_BACKSPACE) begin
          if (cur_column > 0) begin
            cur_column--;
            screen[cur_line][cur_column] = {it.attr, CHAR_SPACE};
          end
        end else begin
          screen[cur_line][cur_column] = {it.attr, it.char_code};
          cur_column++;
        end
        if (cur_column >= COLS) begin
          cur_column = 0;
          cur_line++;
        end
        if (cur_line >= LINES) begin
          // shift every row up and blank the bottom one
          for (int r = 0; r < LINES - 1; r++)
            for (int c = 0; c < COLS; c++)
              screen[r][c] = screen[r + 1][c];
          for (int c = 0; c < COLS; c++)
            screen[LINES - 1][c] = BLANK_CELL;
          cur_line = LINES - 1;
          rep.scrolled = 1'b1;
        end
      end
      KIND_READ: begin
        if (it.row < LINES && it.col < COLS)
          {rep.attr, rep.ch} = screen[it.row][it.col];
      end
      KIND_CLEAR: blank_screen();
      default: ;
    endcase
    rep.row = cur_line[CURSOR_ROW_W-1:0];
    rep.col = cur_column[CURSOR_COL_W-1:0];
    return rep;
  endfunction

  // Present one item, hold it until the transfer, then record what it should report.
  task automatic send_item(input console_item_t it, input logic typed = 1'b0,
                           input console_report_t want = '0);
    console_report_t rep;
    while (!quiet && $urandom_range(0, 99) < 20) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    kind <= it.kind;
    char_code <= it.char_code;
    attribute <= it.attr;
    read_row <= it.row;
    read_col <= it.col;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    rep = console_apply(it);
    awaited_reports.push_back(typed ? want : rep);
    if (it.kind != KIND_NONE &&
        !(it.kind == KIND_READ && (it.row >= LINES || it.col >= COLS)))
      counted_items++;
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] ch);
    send_item('{KIND_PUT, ch, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                7'($urandom_range(0, 127))});
  endtask

  task automatic drain_reports();
    item_valid <= 1'b0;
    @(posedge clk);
    while (awaited_reports.size() != 0) @(posedge clk);
  endtask

  console_step_t directed_steps [STEP_COUNT] = '{
    '{'{KIND_READ, 8'h00, 8'h00, 5'd0, 7'd0}, 1'b1, '{CHAR_SPACE, BLANK_ATTR, 5'd0, 7'd0, 1'b0}},
    '{'{KIND_READ, 8'h00, 8'h00, 5'd24, 7'd79}, 1'b1, '{CHAR_SPACE, BLANK_ATTR, 5'd0, 7'd0, 1'b0}},
    '{'{KIND_READ, 8'h00, 8'h00, 5'd25, 7'd0}, 1'b1, '{8'h00, 8'h00, 5'd0, 7'd0, 1'b0}},
    '{'{KIND_READ, 8'hFF, 8'hFF, 5'd31, 7'd127}, 1'b1, '{8'h00, 8'h00, 5'd0, 7'd0, 1'b0}},
    '{'{KIND_READ, 8'h00, 8'h00, 5'd0, 7'd80}, 1'b1, '{8'h00, 8'h00, 5'd0, 7'd0, 1'b0}},
    '{'{KIND_PUT, 8'h41, 8'h1E, 5'd0, 7'd0}, 1'b1, '{8'h00, 8'h00, 5'd0, 7'd1, 1'b0}},
    '{'{KIND_PUT, 8'hFF, 8'hFF, 5'd31, 7'd127}, 1'b1, '{8'h00, 8'h00, 5'd0, 7'd2, 1'b0}},
    '{'{KIND_PUT, 8'h00, 8'h00, 5'd0, 7'd0}, 1'b1, '{8'h00, 8'h00, 5'd0, 7'd3, 1'b0}},
    '{'{KIND_READ, 8'h00, 8'h00, 5'd0, 7'd1}, 1'b1, '{8'hFF, 8'hFF, 5'd0, 7'd3, 1'b0}},
    '{'{KIND_READ, 8'h00, 8'h00, 5'd0, 7'd2}, 1'b1, '{8'h00, 8'h00, 5'd0, 7'd3, 1'b0}},
    '{'{KIND_PUT, CHAR_BACKSPACE, 8'h70, 5'd0, 7'd0}, 1'b1, '{8'h00, 8'h00, 5'd0, 7'd2, 1'b0}},
    '{'{KIND_READ, 8'h00, 8'h00, 5'd0, 7'd2}, 1'b1, '{CHAR_SPACE, 8'h70, 5'd0, 7'd2, 1'b0}},
    '{'{KIND_PUT, CHAR_NEWLINE, 8'h00, 5'd0, 7'd0}, 1'b1, '{8'h00, 8'h00, 5'd1, 7'd0, 1'b0}},
    '{'{KIND_PUT, CHAR_BACKSPACE, 8'hAA, 5'd0, 7'd0}, 1'b1, '{8'h00, 8'h00, 5'd1, 7'd0, 1'b0}},
    '{'{KIND_READ, 8'h00, 8'h00, 5'd1, 7'd0}, 1'b1, '{CHAR_SPACE, BLANK_ATTR, 5'd1, 7'd0, 1'b0}},
    '{'{KIND_NONE, 8'hFF, 8'hFF, 5'd0, 7'd0}, 1'b1, '{8'h00, 8'h00, 5'd1, 7'd0, 1'b0}},
    '{'{KIND_PUT, 8'h5A, 8'h55, 5'd0, 7'd0}, 1'b0, '0},
    '{'{KIND_READ, 8'h00, 8'h00, 5'd1, 7'd0}, 1'b0, '0},
    '{'{KIND_CLEAR, 8'h00, 8'h00, 5'd0, 7'd0}, 1'b1, '{8'h00, 8'h00, 5'd0, 7'd0, 1'b0}},
    '{'{KIND_READ, 8'h00, 8'h00, 5'd0, 7'd0}, 1'b1, '{CHAR_SPACE, BLANK_ATTR, 5'd0, 7'd0, 1'b0}},
    '{'{KIND_READ, 8'h00, 8'h00, 5'd0, 7'd1}, 1'b1, '{CHAR_SPACE, BLANK_ATTR, 5'd0, 7'd0, 1'b0}},
    '{'{KIND_PUT, CHAR_NEWLINE, 8'hFF, 5'd31, 7'd127}, 1'b0, '0}
  };

  always @(posedge clk) begin
    result_stall <= !quiet && ($urandom_range(0, 99) < 20);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      got_report = {cell_char, cell_attr, cursor_row, cursor_col, scrolled};
      if (awaited_reports.size() == 0) begin
        $display("%0t: result with nothing expected: got %h", $time, got_report);
        mismatch_count++;
      end else begin
        want_report = awaited_reports.pop_front();
        if (got_report !== want_report) begin
          $display("%0t: mismatch: expected char %h attr %h row %0d col %0d scrolled %0d,",
                   $time, want_report.ch, want_report.attr, want_report.row,
                   want_report.col, want_report.scrolled);
          $display("%0t:           actual char %h attr %h row %0d col %0d scrolled %0d",
                   $time, got_report.ch, got_report.attr, got_report.row,
                   got_report.col, got_report.scrolled);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int seg;
    int n;
    int r;
    blank_screen();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < STEP_COUNT; i++)
      send_item(directed_steps[i].item, directed_steps[i].typed, directed_steps[i].want);
    drain_reports();

    counted_items = 0;
    while (counted_items < RANDOM_ITEMS) begin
      quiet = (counted_items >= 200 && counted_items < 300);
      seg = $urandom_range(0, 19);
      if (seg < 8) begin
        // a run of text, long enough at times to wrap the row
        n = $urandom_range(1, 90);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 9) == 0) put_char(CHAR_BACKSPACE);
          else put_char(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 1) == 1) put_char(CHAR_NEWLINE);
      end else if (seg < 11) begin
        n = $urandom_range(1, 30);
        for (int i = 0; i < n; i++) put_char(CHAR_NEWLINE);
      end else if (seg < 17) begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          r = ($urandom_range(0, 1) == 1) ? cur_line : $urandom_range(0, LINES - 1);
          send_item('{KIND_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      5'(r), 7'($urandom_range(0, COLS - 1))});
        end
      end else if (seg == 17) begin
        drain_reports();
      end else begin
        case ($urandom_range(0, 3))
          0: send_item('{KIND_NONE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         5'($urandom_range(0, 31)), 7'($urandom_range(0, 127))});
          1: send_item('{KIND_READ, 8'h00, 8'h00, 5'($urandom_range(LINES, 31)),
                         7'($urandom_range(0, 127))});
          2: send_item('{KIND_READ, 8'h00, 8'h00, 5'($urandom_range(0, 31)),
                         7'($urandom_range(COLS, 127))});
          default: send_item('{KIND_CLEAR, 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                               7'($urandom_range(0, 127))});
        endcase
      end
    end
    quiet = 1'b0;

    drain_reports();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && awaited_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/tcw_pkg.sv
src/tcw_ram.sv
src/tcw_front.sv
src/tcw_queue.sv
src/tcw_back.sv
src/text_console_writer.sv
test/text_console_writer_test.sv
